/* rtl/core/tha_pkg.sv */
package tha_pkg;

	// Default history depth and fixed field widths.
	localparam int HIST_DEPTH_DEF = 12;
	localparam int ADC_W          = 12;
	localparam int TEMP_W         = 8;
	localparam int LAST_TEMP_W    = 8;
	localparam int AVG_W          = 11;

	// Millivolt conversion: mV = (ADC_MV_SCALE * code) >> ADC_SHIFT.
	localparam int ADC_MV_SCALE   = 1200;
	localparam int ADC_SHIFT      = 12;
	localparam int MV_W           = 11;
	localparam int MV_PROD_W      = ADC_W + MV_W;

	// Degrees: DEG_OFFSET + trunc((mV - MV_OFFSET) / 10).
	localparam int MV_OFFSET      = 750;
	localparam int DEG_OFFSET     = 25;
	localparam int DIFF_W         = 12;
	localparam int DIFF_MAG_W     = 10;

	// Division by ten as a reciprocal multiply, exact for magnitudes below 1029.
	localparam int RECIP_TEN      = 205;
	localparam int RECIP_SHIFT    = 11;
	localparam int RECIP_W        = 8;
	localparam int RECIP_PROD_W   = DIFF_MAG_W + RECIP_W;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_STORE,
		ST_SUM,
		ST_SCALE,
		ST_DIV,
		ST_FINISH
	} state_t;

endpackage

/* rtl/core/temperature_history_averager_unit.sv */
// Temperature history averager: converts ADC samples to degrees, keeps a ring of them in a RAM,
// and averages the ring on a button press edge.
// A good sample goes through convert, store and finish; an error sample or a poll without a press
// edge goes to finish; a press walks the RAM reads, scales the sum and runs the bit-serial divider.
// A new item is taken only in idle; a stalled output holds the unit in finish.
// Reset clears counters, button history, latest temperature and output valid; the RAM is not cleared.
module temperature_history_averager_unit #(
	parameter int HISTORY_DEPTH = tha_pkg::HIST_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   kind,
	input  logic [tha_pkg::ADC_W-1:0]              adc_code,
	input  logic                                   adc_error,
	input  logic                                   button_level,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [tha_pkg::LAST_TEMP_W-1:0] last_temperature,
	output logic signed [tha_pkg::AVG_W-1:0]       average_tenths,
	output logic                                   average_valid,
	output logic                                   overflow_led
);

	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W  = $clog2(HISTORY_DEPTH + 2);
	localparam int SUM_W  = tha_pkg::TEMP_W + $clog2(HISTORY_DEPTH + 1);
	localparam int PROD_W = SUM_W + 4;

	tha_pkg::state_t state_q, state_d;

	logic                              prev_button_q;
	logic [CNT_W-1:0]                  count_q;
	logic [SLOT_W-1:0]                 slot_q;
	logic [tha_pkg::TEMP_W-1:0]        latest_q;
	logic [tha_pkg::ADC_W-1:0]         code_q;
	logic [tha_pkg::MV_W-1:0]          mv_q;
	logic [CNT_W-1:0]                  n_q;
	logic [CNT_W-1:0]                  idx_q;
	logic                              rd_vld_s1;
	logic [SUM_W-1:0]                  sum_q;
	logic                              neg_q;
	logic [tha_pkg::AVG_W-1:0]         avg_res_q;
	logic                              avg_vld_q;

	logic                              out_valid_q;
	logic [tha_pkg::TEMP_W-1:0]        out_temp_q;
	logic [tha_pkg::AVG_W-1:0]         out_avg_q;
	logic                              out_avg_vld_q;
	logic                              out_ovf_q;

	logic                              accept;
	logic                              press_edge;
	logic                              out_free;
	logic                              ram_we;
	logic                              rd_issue;
	logic                              div_start;
	logic                              out_load;
	logic                              div_done;
	logic [PROD_W-1:0]                 div_quo;
	logic [tha_pkg::TEMP_W-1:0]        rd_data;

	logic [tha_pkg::MV_PROD_W-1:0]     mv_prod;
	logic [tha_pkg::DIFF_W-1:0]        diff;
	logic                              diff_neg;
	logic [tha_pkg::DIFF_W-1:0]        diff_abs;
	logic [tha_pkg::RECIP_PROD_W-1:0]  q_prod;
	logic [tha_pkg::TEMP_W-1:0]        deg_q10;
	logic [tha_pkg::TEMP_W-1:0]        temp;
	logic [PROD_W-1:0]                 sum_ext;
	logic [PROD_W-1:0]                 prod;
	logic [PROD_W-1:0]                 prod_mag;
	logic [PROD_W-1:0]                 avg_full;

	assign accept     = in_valid && !in_stall;
	assign press_edge = button_level && !prev_button_q;
	assign out_free   = !out_valid_q || !out_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tha_pkg::ST_IDLE: begin
				if (in_valid) begin
					if (!kind) begin
						state_d = adc_error ? tha_pkg::ST_FINISH : tha_pkg::ST_CONV;
					end else if (press_edge && (count_q != '0)) begin
						state_d = tha_pkg::ST_SUM;
					end else begin
						state_d = tha_pkg::ST_FINISH;
					end
				end
			end
			tha_pkg::ST_CONV:  state_d = tha_pkg::ST_STORE;
			tha_pkg::ST_STORE: state_d = tha_pkg::ST_FINISH;
			tha_pkg::ST_SUM: begin
				if ((idx_q == n_q) && !rd_vld_s1) begin
					state_d = tha_pkg::ST_SCALE;
				end
			end
			tha_pkg::ST_SCALE: state_d = tha_pkg::ST_DIV;
			tha_pkg::ST_DIV: begin
				if (div_done) begin
					state_d = tha_pkg::ST_FINISH;
				end
			end
			tha_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = tha_pkg::ST_IDLE;
				end
			end
			default: state_d = tha_pkg::ST_IDLE;
		endcase
	end

	// Control outputs of the state machine.
	always_comb begin
		in_stall  = (state_q != tha_pkg::ST_IDLE);
		ram_we    = (state_q == tha_pkg::ST_STORE);
		rd_issue  = (state_q == tha_pkg::ST_SUM) && (idx_q != n_q);
		div_start = (state_q == tha_pkg::ST_SCALE);
		out_load  = (state_q == tha_pkg::ST_FINISH) && out_free;
	end

	// Sample conversion: millivolts, then whole degrees with truncation toward zero.
	always_comb begin
		mv_prod  = tha_pkg::MV_PROD_W'(code_q) * tha_pkg::MV_PROD_W'(tha_pkg::ADC_MV_SCALE);
		diff     = {1'b0, mv_q} - tha_pkg::DIFF_W'(tha_pkg::MV_OFFSET);
		diff_neg = diff[tha_pkg::DIFF_W-1];
		diff_abs = diff_neg ? (~diff + tha_pkg::DIFF_W'(1)) : diff;
		q_prod   = tha_pkg::RECIP_PROD_W'(diff_abs[tha_pkg::DIFF_MAG_W-1:0])
			* tha_pkg::RECIP_PROD_W'(tha_pkg::RECIP_TEN);
		deg_q10  = tha_pkg::TEMP_W'(q_prod[tha_pkg::RECIP_PROD_W-1:tha_pkg::RECIP_SHIFT]);
		temp     = diff_neg ? (tha_pkg::TEMP_W'(tha_pkg::DEG_OFFSET) - deg_q10)
			: (tha_pkg::TEMP_W'(tha_pkg::DEG_OFFSET) + deg_q10);
	end

	// Sum times ten as shifts, split into sign and magnitude for the divider.
	always_comb begin
		sum_ext  = {{(PROD_W - SUM_W){sum_q[SUM_W-1]}}, sum_q};
		prod     = (sum_ext << 3) + (sum_ext << 1);
		prod_mag = prod[PROD_W-1] ? (~prod + PROD_W'(1)) : prod;
		avg_full = neg_q ? (~div_quo + PROD_W'(1)) : div_quo;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= tha_pkg::ST_IDLE;
			prev_button_q <= 1'b0;
			count_q       <= '0;
			slot_q        <= '0;
			latest_q      <= '0;
			idx_q         <= '0;
			rd_vld_s1     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_issue;
			if (accept) begin
				idx_q <= '0;
				if (kind) begin
					prev_button_q <= button_level;
					if (press_edge) begin
						count_q <= '0;
						slot_q  <= '0;
					end
				end
			end
			if (ram_we) begin
				latest_q <= temp;
				slot_q   <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
				if (count_q <= CNT_W'(HISTORY_DEPTH)) begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (rd_issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q    <= adc_code;
			sum_q     <= '0;
			avg_res_q <= '0;
			avg_vld_q <= 1'b0;
			n_q       <= (count_q > CNT_W'(HISTORY_DEPTH)) ? CNT_W'(HISTORY_DEPTH) : count_q;
		end
		if (state_q == tha_pkg::ST_CONV) begin
			mv_q <= mv_prod[tha_pkg::ADC_SHIFT +: tha_pkg::MV_W];
		end
		if (rd_vld_s1) begin
			sum_q <= sum_q + {{(SUM_W - tha_pkg::TEMP_W){rd_data[tha_pkg::TEMP_W-1]}}, rd_data};
		end
		if (div_start) begin
			neg_q <= prod[PROD_W-1];
		end
		if ((state_q == tha_pkg::ST_DIV) && div_done) begin
			avg_res_q <= avg_full[tha_pkg::AVG_W-1:0];
			avg_vld_q <= 1'b1;
		end
		if (out_load) begin
			out_temp_q    <= latest_q;
			out_avg_q     <= avg_res_q;
			out_avg_vld_q <= avg_vld_q;
			out_ovf_q     <= (count_q > CNT_W'(HISTORY_DEPTH));
		end
	end

	// History ring.
	tha_ram #(
		.WIDTH (tha_pkg::TEMP_W),
		.DEPTH (HISTORY_DEPTH),
		.ADDR_W(SLOT_W)
	) u_history (
		.clk    (clk),
		.wr_en  (ram_we),
		.wr_addr(slot_q),
		.wr_data(temp),
		.rd_addr(idx_q[SLOT_W-1:0]),
		.rd_data(rd_data)
	);

	// Bit-serial divider for the average.
	tha_div #(
		.DVD_W(PROD_W),
		.DVS_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod_mag),
		.divisor (n_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Result beat.
	assign out_valid        = out_valid_q;
	assign last_temperature = out_temp_q;
	assign average_tenths   = out_avg_q;
	assign average_valid    = out_avg_vld_q;
	assign overflow_led     = out_ovf_q;

endmodule

/* rtl/core/tha_ram.sv */
module tha_ram #(
	parameter int WIDTH = tha_pkg::TEMP_W,
	parameter int DEPTH = tha_pkg::HIST_DEPTH_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one read port with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/core/tha_div.sv */
module tha_div #(
	parameter int DVD_W = 15,
	parameter int DVS_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	// One restoring step: shift in the next dividend bit and try the subtract.
	always_comb begin
		trial = {rem_q, quo_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	// Control of the iteration, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
